FILE: src/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA block cipher package
// Shared types, constants and round-sum helper for the TEA round chain.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned ROUNDS    = 1024;
  localparam int unsigned CELLS     = 2 * ROUNDS;  // one cell per half-round
  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_DECRYPT = 3'd4
  } cfg_reg_e;

  // Key words and mode as seen by every cell
  typedef struct packed {
    word_t key0;
    word_t key1;
    word_t key2;
    word_t key3;
    logic  decrypt;
  } cfg_t;

  // Payload that moves along the chain
  typedef struct packed {
    word_t a;     // first word, block bits 63..32
    word_t b;     // second word, block bits 31..0
    logic  last;
  } stage_t;

  // delta * n mod 2^32, evaluated at elaboration
  function automatic word_t round_sum(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(n);
    return prod[31:0];
  endfunction

endpackage

FILE: src/tea_cfg_regs.sv
// ----------------------------------------------------------------------------
// TEA configuration registers
// Key words and encrypt/decrypt mode, written through an indexed port.
// ----------------------------------------------------------------------------
module tea_cfg_regs import tea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_KEY0:    cfg_d.key0    = cfg_data_i;
        REG_KEY1:    cfg_d.key1    = cfg_data_i;
        REG_KEY2:    cfg_d.key2    = cfg_data_i;
        REG_KEY3:    cfg_d.key3    = cfg_data_i;
        REG_DECRYPT: cfg_d.decrypt = cfg_data_i[0];
        default:     cfg_d = cfg_q;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/tea_round_cell.sv
// ----------------------------------------------------------------------------
// TEA half-round cell
// One half-round of TEA (encrypt or decrypt), registered, with a valid bit.
// ----------------------------------------------------------------------------
module tea_round_cell import tea_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  cfg_t   cfg_i,
  input  word_t  sum_i,
  input  logic   half_i,    // 0: even cell of a round, 1: odd cell
  input  logic   valid_i,
  input  stage_t data_i,
  output logic   valid_o,
  output stage_t data_o
);

  logic   valid_q;
  stage_t data_q, data_d;
  logic   upd_a;
  word_t  src, dst, ka, kb, mix, res;

  // Encrypt updates a then b; decrypt runs the halves in reverse
  assign upd_a = ~(half_i ^ cfg_i.decrypt);

  always_comb begin
    src = upd_a ? data_i.b : data_i.a;
    dst = upd_a ? data_i.a : data_i.b;
    ka  = upd_a ? cfg_i.key0 : cfg_i.key2;
    kb  = upd_a ? cfg_i.key1 : cfg_i.key3;
    mix = ((src << 4) + ka) ^ (src + sum_i) ^ ((src >> 5) + kb);
    res = cfg_i.decrypt ? (dst - mix) : (dst + mix);
    data_d = data_i;
    if (upd_a) begin
      data_d.a = res;
    end else begin
      data_d.b = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: src/tea_out_skid.sv
// ----------------------------------------------------------------------------
// TEA output stage
// Output register plus skid entry; holds the chain only when both are full.
// ----------------------------------------------------------------------------
module tea_out_skid import tea_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  stage_t in_data_i,
  output logic   in_ready_o,
  output logic   out_valid_o,
  output stage_t out_data_o,
  input  logic   out_ready_i
);

  logic   out_valid_q, out_valid_d;
  logic   skid_valid_q, skid_valid_d;
  stage_t out_data_q, out_data_d;
  stage_t skid_data_q, skid_data_d;
  logic   in_take;

  assign in_ready_o = ~skid_valid_q;
  assign in_take    = in_valid_i & ~skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_take;
        out_data_d  = in_data_i;
      end
    end else if (in_take) begin
      // output still waiting: park the arriving result
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: src/tea_block_cipher_unit.sv
// Path: an input block passes through the 2048 half-round cells, then the
// output register, before m_axis_tvalid is raised for it.
// Throughput: one block per cycle while the chain is not stalled; the chain of 2048 cells holds 2048 blocks.
// The chain stalls only when both the output register and skid entry are full.
// Reset (async, active low) clears valid bits, key words and mode to zero.
// ----------------------------------------------------------------------------
// TEA block cipher unit
// 1024-round TEA encrypt/decrypt on 64-bit blocks as a chain of round cells.
// ----------------------------------------------------------------------------
module tea_block_cipher_unit import tea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input blocks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // block_in[63:0]
  input  logic        s_axis_tlast,   // last_block
  // result blocks
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // block_out[63:0]
  output logic        m_axis_tlast    // last_block_out
);

  cfg_t   cfg;
  logic   chain_en;
  logic   stg_valid [CELLS+1];
  stage_t stg_data  [CELLS+1];
  stage_t out_data;

  tea_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign s_axis_tready = chain_en;
  assign stg_valid[0]  = s_axis_tvalid;
  assign stg_data[0]   = '{a: s_axis_tdata[63:32], b: s_axis_tdata[31:0], last: s_axis_tlast};

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    localparam word_t EncSum  = round_sum(g / 2 + 1);
    localparam word_t DecSum  = round_sum(ROUNDS - g / 2);
    localparam logic  HalfSel = 1'(g % 2);
    word_t sum;

    assign sum = cfg.decrypt ? DecSum : EncSum;

    tea_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (chain_en),
      .cfg_i   (cfg),
      .sum_i   (sum),
      .half_i  (HalfSel),
      .valid_i (stg_valid[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_valid[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  tea_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[CELLS]),
    .in_data_i   (stg_data[CELLS]),
    .in_ready_o  (chain_en),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_data),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {out_data.a, out_data.b};
  assign m_axis_tlast = out_data.last;

endmodule

FILE: src/tea_chk.sv
// ----------------------------------------------------------------------------
// TEA port checker
// Port-level assertions for the TEA block cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
module tea_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // input is refused only while a result is waiting at the output
  a_block_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input blocked with no pending result");

  // input ready drops only after a result sat untaken
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input ready dropped without output stall");

  // input ready returns only after the output transfer drained the skid entry
  a_ready_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> $past(m_axis_tvalid && m_axis_tready))
    else $error("input ready returned without output transfer");

endmodule

bind tea_block_cipher_unit tea_chk u_tea_chk (.*);
